// ===== hw/rtl/wbr_pkg.sv =====
// wbr_pkg: shared types and constants for the wind bin ring block
// item structs, request codes, bin entry layout and controller states
// no dependencies
package wbr_pkg;

  // default configuration of the ring
  localparam int DEPTH_DEF = 32;
  localparam int TOP_K_DEF = 7;

  // rank of the reported gust within the descending buffer (fifth highest)
  localparam int GUST_RANK = 4;

  // bin length after reset
  localparam logic [31:0] BIN_STEP_RST = 32'd60;

  // request codes
  localparam logic [1:0] REQ_WIND  = 2'd0;
  localparam logic [1:0] REQ_GUST  = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  // input item
  typedef struct packed {
    logic [1:0]         req_type;
    logic [31:0]        now;
    logic signed [15:0] sample_tenths;
    logic [31:0]        query_age;
  } req_t;

  // result item
  typedef struct packed {
    logic [15:0] mean_wind;
    logic [15:0] gust_fifth;
    logic [5:0]  sample_count;
    logic        valid_res;
  } res_t;

  // one bin of the ring memory
  typedef struct packed {
    logic [15:0] wind;
    logic [15:0] gust;
    logic [31:0] stamp;
  } bin_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_SCAN,
    ST_DIV,
    ST_WAIT,
    ST_FIN
  } state_t;

endpackage

// ===== hw/rtl/wind_bin_ring_gust_kth_largest.sv =====
// wind_bin_ring_gust_kth_largest: ring of time-stamped wind/gust bins with windowed query
// depends on wbr_pkg and wbr_div
// bins live in one synchronous memory with per-entry valid bits
//
// The bins sit in a single memory with a registered read. An add item is read, then modified and
// written back; the bin closes and the write position moves on when the current bin is
// stamped and older than bin_step. A query item reads all DEPTH bins, one per cycle through
// the memory read port, keeping the sum, count and a sorted top-TOP_K gust buffer, then, if
// any bin is in the window, runs a bit-serial divider for the mean; there is one result
// item per query. Reset clears the per-entry valid bits at once, so there is no clearing
// pass; a bin never written reads as zero and unstamped. One item is in work at a time;
// further add items are taken while a query result waits on the output.
module wind_bin_ring_gust_kth_largest #(
  parameter int DEPTH = wbr_pkg::DEPTH_DEF,
  parameter int TOP_K = wbr_pkg::TOP_K_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [31:0]   cfg_data,
  input  logic          in_valid,
  output logic          in_ready,
  input  wbr_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output wbr_pkg::res_t out_data
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = 16 + CNT_W;

  wbr_pkg::state_t state, state_next;
  logic [31:0]     bin_step;
  logic [IDX_W-1:0] write_pos;
  logic [DEPTH-1:0] bin_vld;
  wbr_pkg::req_t   req;

  // memory ports
  wbr_pkg::bin_t   mem [DEPTH];
  wbr_pkg::bin_t   rd_q, rd_entry, wr_entry;
  logic            rd_vld;
  logic [IDX_W-1:0] rd_addr, wr_addr, pos_inc;
  logic            wr_en;

  // scan state
  logic [CNT_W-1:0] issue_idx;
  logic [CNT_W-1:0] cnt;
  logic [SUM_W-1:0] sum;
  logic [15:0]      topk [TOP_K];
  logic [15:0]      topk_next [TOP_K];
  logic [TOP_K-1:0] keep;
  logic [TOP_K-1:0] prev_keep;
  logic [15:0]      prev_val [TOP_K];
  logic             incl;

  // add path
  logic        adv;
  logic        neg;
  logic [15:0] raw;
  logic [15:0] wind_val, gust_val;

  // divider and output
  logic             div_start, div_done, out_load, accept;
  logic [SUM_W-1:0] quotient;
  logic [CNT_W+5:0] cnt_ext;
  wbr_pkg::res_t    res;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == wbr_pkg::ST_IDLE);
  assign accept    = in_valid && in_ready;

  // masked read data: a never-written bin reads as zero
  assign rd_entry = rd_vld ? rd_q : '0;

  // bin close and sample conditioning
  assign pos_inc  = (write_pos == IDX_W'(DEPTH - 1)) ? '0 : write_pos + 1'b1;
  assign adv      = (rd_entry.stamp != 32'd0) && ((req.now - rd_entry.stamp) > bin_step);
  assign raw      = req.sample_tenths;
  assign neg      = raw[15];
  assign wind_val = neg ? 16'd0 : raw;
  assign gust_val = neg ? 16'(17'h10000 - {1'b0, raw}) : raw;

  // window membership of the bin being scanned
  assign incl = (rd_entry.stamp != 32'd0) && ((req.now - rd_entry.stamp) < req.query_age);

  // sorted insert into the descending gust buffer, duplicates kept
  always_comb begin
    for (int j = 0; j < TOP_K; j++) begin
      keep[j] = topk[j] >= rd_entry.gust;
    end
    prev_keep[0] = 1'b1;
    prev_val[0]  = rd_entry.gust;
    for (int j = 1; j < TOP_K; j++) begin
      prev_keep[j] = keep[j-1];
      prev_val[j]  = topk[j-1];
    end
    for (int j = 0; j < TOP_K; j++) begin
      if (keep[j]) begin
        topk_next[j] = topk[j];
      end else if (prev_keep[j]) begin
        topk_next[j] = rd_entry.gust;
      end else begin
        topk_next[j] = prev_val[j];
      end
    end
  end

  // next state and strobes
  always_comb begin
    state_next = state;
    rd_addr    = write_pos;
    wr_en      = 1'b0;
    wr_addr    = write_pos;
    wr_entry   = '0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      wbr_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (in_data.req_type) inside
            wbr_pkg::REQ_WIND, wbr_pkg::REQ_GUST: begin
              rd_addr    = write_pos;
              state_next = wbr_pkg::ST_ADD;
            end
            wbr_pkg::REQ_QUERY: begin
              rd_addr    = '0;
              state_next = wbr_pkg::ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      wbr_pkg::ST_ADD: begin
        wr_en          = 1'b1;
        wr_addr        = adv ? pos_inc : write_pos;
        wr_entry.wind  = (req.req_type == wbr_pkg::REQ_WIND) ? wind_val : rd_entry.wind;
        wr_entry.gust  = (req.req_type == wbr_pkg::REQ_GUST) ? gust_val : rd_entry.gust;
        wr_entry.stamp = req.now;
        state_next     = wbr_pkg::ST_IDLE;
      end
      wbr_pkg::ST_SCAN: begin
        rd_addr = issue_idx[IDX_W-1:0];
        if (issue_idx == CNT_W'(DEPTH)) begin
          state_next = wbr_pkg::ST_DIV;
        end
      end
      wbr_pkg::ST_DIV: begin
        if (cnt == '0) begin
          state_next = wbr_pkg::ST_FIN;
        end else begin
          div_start  = 1'b1;
          state_next = wbr_pkg::ST_WAIT;
        end
      end
      wbr_pkg::ST_WAIT: begin
        if (div_done) begin
          state_next = wbr_pkg::ST_FIN;
        end
      end
      wbr_pkg::ST_FIN: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = wbr_pkg::ST_IDLE;
        end
      end
      default: state_next = wbr_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= wbr_pkg::ST_IDLE;
      bin_step  <= wbr_pkg::BIN_STEP_RST;
      write_pos <= '0;
      bin_vld   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        bin_step <= cfg_data;
      end
      if (wr_en) begin
        write_pos        <= wr_addr;
        bin_vld[wr_addr] <= 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // bin memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    rd_q   <= mem[rd_addr];
    rd_vld <= bin_vld[rd_addr];
  end

  // item latch and scan accumulators
  always_ff @(posedge clk) begin
    if (accept) begin
      req <= in_data;
    end
    if (accept && in_data.req_type == wbr_pkg::REQ_QUERY) begin
      issue_idx <= CNT_W'(1);
      cnt       <= '0;
      sum       <= '0;
      for (int j = 0; j < TOP_K; j++) begin
        topk[j] <= '0;
      end
    end else if (state == wbr_pkg::ST_SCAN) begin
      if (issue_idx != CNT_W'(DEPTH)) begin
        issue_idx <= issue_idx + 1'b1;
      end
      if (incl) begin
        sum <= sum + SUM_W'(rd_entry.wind);
        cnt <= cnt + 1'b1;
        for (int j = 0; j < TOP_K; j++) begin
          topk[j] <= topk_next[j];
        end
      end
    end
  end

  // mean of the included wind values
  wbr_div #(
    .DVD_W(SUM_W),
    .DVS_W(CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum),
    .divisor  (cnt),
    .done     (div_done),
    .quotient (quotient)
  );

  // result assembly
  assign cnt_ext = {6'd0, cnt};
  always_comb begin
    res.mean_wind    = (cnt == '0) ? 16'd0 : quotient[15:0];
    res.gust_fifth   = (cnt == '0) ? 16'd0 : topk[wbr_pkg::GUST_RANK];
    res.sample_count = cnt_ext[5:0];
    res.valid_res    = (cnt != '0);
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= res;
    end
  end

`ifndef NO_ASSERTIONS
  // an add item is read and written back, then the block is ready again
  a_add_two_cycles: assert property (@(posedge clk) disable iff (rst)
    accept && (in_data.req_type == wbr_pkg::REQ_WIND || in_data.req_type == wbr_pkg::REQ_GUST)
    |=> ##1 in_ready)
    else $error("add item did not complete in two cycles");

  // the count never runs ahead of the bins already read
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    state == wbr_pkg::ST_SCAN |-> cnt < issue_idx)
    else $error("window count exceeds bins scanned");

  // a result item only appears out of the finish state
  a_out_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == wbr_pkg::ST_FIN))
    else $error("result item raised outside finish state");
`endif

endmodule

// ===== hw/rtl/wbr_div.sv =====
// wbr_div: iterative restoring divider, one quotient bit per cycle
// used by the top level for the windowed mean
// no package dependencies
module wbr_div #(
  parameter int DVD_W = 22,
  parameter int DVS_W = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [DVS_W-1:0]  rem;
  logic [DVD_W-1:0]  quo;
  logic [DVS_W:0]    trial;
  logic              fits;

  // shift in the next dividend bit and try the subtract
  assign trial = {rem, quo[DVD_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && step == STEP_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo  <= dividend;
      rem  <= '0;
      step <= STEP_W'(DVD_W);
    end else if (busy) begin
      step <= step - 1'b1;
      if (fits) begin
        rem <= DVS_W'(trial - {1'b0, divisor});
        quo <= {quo[DVD_W-2:0], 1'b1};
      end else begin
        rem <= trial[DVS_W-1:0];
        quo <= {quo[DVD_W-2:0], 1'b0};
      end
    end
  end

  assign quotient = quo;

endmodule

// ===== test/wind_bin_ring_gust_kth_largest_test.sv =====
// wind_bin_ring_gust_kth_largest_test: self-checking bench for the wind bin ring
// drives add, query and unused items plus bin_step writes, predicts every window summary
// depends on wbr_pkg and the wind_bin_ring_gust_kth_largest rtl
module wind_bin_ring_gust_kth_largest_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          RING_DEPTH   = wbr_pkg::DEPTH_DEF;
  localparam logic [1:0]  REQ_UNUSED   = 2'd3;
  localparam int          QUIET_CYCLES = 80;
  localparam int          DRAIN_LIMIT  = 20000;
  localparam int          REPORT_MAX   = 10;

  // block ports
  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [31:0]   cfg_data = '0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  wbr_pkg::req_t in_data = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  wbr_pkg::res_t out_data;

  // predicted ring contents and register
  logic [15:0] ring_wind  [RING_DEPTH];
  logic [15:0] ring_gust  [RING_DEPTH];
  logic [31:0] ring_stamp [RING_DEPTH];
  int unsigned ring_pos;
  logic [31:0] bin_step_m;

  // window summaries still owed by the block
  wbr_pkg::res_t pending_summaries [$];

  // pacing and bookkeeping
  int unsigned snd_idle_pct = 14;
  int unsigned rcv_idle_pct = 66;
  logic [31:0] sim_clock = '0;
  int unsigned time_stride = 100;
  int unsigned mismatches = 0;
  int unsigned n_adds = 0;
  int unsigned n_queries = 0;
  int unsigned n_filled = 0;
  int unsigned n_ignored = 0;
  int unsigned n_steps = 0;

  wind_bin_ring_gust_kth_largest u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  // reset state of the predicted ring
  initial begin
    for (int i = 0; i < RING_DEPTH; i++) begin
      ring_wind[i]  = '0;
      ring_gust[i]  = '0;
      ring_stamp[i] = '0;
    end
    ring_pos   = 0;
    bin_step_m = wbr_pkg::BIN_STEP_RST;
  end

  // add a wind or gust sample, closing the current bin when it has aged out
  function automatic void apply_sample(input wbr_pkg::req_t r);
    int unsigned p;
    int unsigned nxt;
    logic [31:0] age;
    logic [15:0] raw;
    p   = ring_pos;
    age = r.now - ring_stamp[p];
    raw = r.sample_tenths;
    if (ring_stamp[p] != '0 && age > bin_step_m) begin
      nxt = (p + 1) % RING_DEPTH;
      ring_wind[nxt]  = ring_wind[p];
      ring_gust[nxt]  = ring_gust[p];
      ring_stamp[nxt] = '0;
      p = nxt;
    end
    ring_pos = p;
    if (r.req_type == wbr_pkg::REQ_WIND)
      ring_wind[p] = raw[15] ? 16'd0 : raw;
    else
      ring_gust[p] = raw[15] ? (~raw + 16'd1) : raw;
    ring_stamp[p] = r.now;
  endfunction

  // mean wind, count and fifth-highest gust over bins younger than the age limit
  function automatic wbr_pkg::res_t window_summary(input logic [31:0] t,
                                                   input logic [31:0] limit);
    wbr_pkg::res_t s;
    logic [31:0]   sum;
    logic [31:0]   age;
    int unsigned   cnt;
    logic [15:0]   top [wbr_pkg::GUST_RANK+1];
    logic [15:0]   g;
    int            j;
    sum = '0;
    cnt = 0;
    for (int i = 0; i <= wbr_pkg::GUST_RANK; i++) top[i] = '0;
    for (int i = 0; i < RING_DEPTH; i++) begin
      age = t - ring_stamp[i];
      if (ring_stamp[i] != '0 && age < limit) begin
        sum = sum + ring_wind[i];
        cnt++;
        g = ring_gust[i];
        // keep the highest gusts sorted, duplicates included
        if (g > top[wbr_pkg::GUST_RANK]) begin
          j = wbr_pkg::GUST_RANK - 1;
          while (j >= 0 && top[j] < g) begin
            top[j+1] = top[j];
            j--;
          end
          top[j+1] = g;
        end
      end
    end
    s.mean_wind    = (cnt != 0) ? 16'(sum / cnt) : 16'd0;
    s.gust_fifth   = (cnt != 0) ? top[wbr_pkg::GUST_RANK] : 16'd0;
    s.sample_count = 6'(cnt);
    s.valid_res    = (cnt != 0);
    return s;
  endfunction

  function automatic wbr_pkg::req_t make_req(input logic [1:0] kind, input logic [31:0] t,
                                             input logic [15:0] sample,
                                             input logic [31:0] limit);
    wbr_pkg::req_t r;
    r.req_type      = kind;
    r.now           = t;
    r.sample_tenths = sample;
    r.query_age     = limit;
    return r;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= REPORT_MAX) $display("mismatch: %s", msg);
  endtask

  // send one item, then update the prediction once it is taken
  task automatic send_req(input wbr_pkg::req_t r);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    case (r.req_type) inside
      wbr_pkg::REQ_WIND, wbr_pkg::REQ_GUST: begin
        apply_sample(r);
        n_adds++;
      end
      wbr_pkg::REQ_QUERY: begin
        pending_summaries.push_back(window_summary(r.now, r.query_age));
        n_queries++;
      end
      default: n_ignored++;
    endcase
  endtask

  // hold the sender until every summary is back, then let the block go quiet
  task automatic settle();
    int n;
    in_valid <= 1'b0;
    n = 0;
    while (pending_summaries.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_bin_step(input logic [31:0] v);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid  <= 1'b0;
    bin_step_m = v;
    n_steps++;
  endtask

  // random item: time mostly creeps forward, sometimes jumps or wraps
  function automatic wbr_pkg::req_t random_req();
    wbr_pkg::req_t r;
    int unsigned   pick;
    pick = $urandom_range(99);
    if (pick < 45)      r.req_type = wbr_pkg::REQ_WIND;
    else if (pick < 78) r.req_type = wbr_pkg::REQ_GUST;
    else if (pick < 97) r.req_type = wbr_pkg::REQ_QUERY;
    else                r.req_type = REQ_UNUSED;
    pick = $urandom_range(99);
    if (pick < 3)      sim_clock = $urandom();
    else if (pick < 5) sim_clock = 32'hFFFF_FFF0 + $urandom_range(15);
    else               sim_clock = sim_clock + $urandom_range(time_stride);
    r.now = (pick == 5) ? 32'd0 : sim_clock;
    pick = $urandom_range(99);
    if (pick < 3)       r.sample_tenths = 16'sh8000;
    else if (pick < 6)  r.sample_tenths = 16'sh7FFF;
    else if (pick < 9)  r.sample_tenths = 16'sh0000;
    else if (pick < 55) r.sample_tenths = 16'($signed($urandom_range(700)) - 100);
    else                r.sample_tenths = 16'($urandom());
    pick = $urandom_range(99);
    if (pick < 8)       r.query_age = '0;
    else if (pick < 22) r.query_age = 32'hFFFF_FFFF;
    else if (pick < 32) r.query_age = $urandom();
    else                r.query_age = $urandom_range(40 * time_stride + 1, 1);
    return r;
  endfunction

  task automatic run_traffic(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      send_req(random_req());
      // occasional full drain mid-stream
      if (i % 60 == 59) settle();
    end
  endtask

  // empty ring, unstamped add at time zero and the unused code
  task automatic test_empty_window();
    send_req(make_req(wbr_pkg::REQ_QUERY, 32'd50, 16'h0000, 32'hFFFF_FFFF));
    send_req(make_req(wbr_pkg::REQ_WIND, 32'd0, 16'd250, 32'd0));
    send_req(make_req(wbr_pkg::REQ_GUST, 32'd0, 16'd300, 32'd0));
    send_req(make_req(wbr_pkg::REQ_QUERY, 32'd5, 16'h0000, 32'hFFFF_FFFF));
    send_req(make_req(REQ_UNUSED, 32'd7, 16'h1234, 32'hFFFF_FFFF));
    send_req(make_req(wbr_pkg::REQ_QUERY, 32'd8, 16'hFFFF, 32'd0));
  endtask

  // bins closing as time moves on, clamp and absolute value, age boundaries
  task automatic test_bin_close();
    send_req(make_req(wbr_pkg::REQ_WIND, 32'd10, 16'd100, 32'd0));
    send_req(make_req(wbr_pkg::REQ_GUST, 32'd20, 16'h8000, 32'd0));
    send_req(make_req(wbr_pkg::REQ_WIND, 32'd30, 16'hFFFB, 32'd0));
    send_req(make_req(wbr_pkg::REQ_QUERY, 32'd40, 16'h0000, 32'hFFFF_FFFF));
    send_req(make_req(wbr_pkg::REQ_GUST, 32'd200, 16'h7FFF, 32'd0));
    send_req(make_req(wbr_pkg::REQ_WIND, 32'd300, 16'h7FFF, 32'd0));
    send_req(make_req(wbr_pkg::REQ_GUST, 32'd400, 16'd5, 32'd0));
    send_req(make_req(wbr_pkg::REQ_GUST, 32'd500, 16'd7, 32'd0));
    send_req(make_req(wbr_pkg::REQ_WIND, 32'd600, 16'h8000, 32'd0));
    send_req(make_req(wbr_pkg::REQ_QUERY, 32'd650, 16'h0000, 32'hFFFF_FFFF));
    send_req(make_req(wbr_pkg::REQ_QUERY, 32'd650, 16'h0000, 32'd0));
    send_req(make_req(wbr_pkg::REQ_QUERY, 32'd650, 16'h0000, 32'd250));
    send_req(make_req(wbr_pkg::REQ_QUERY, 32'd650, 16'h0000, 32'd251));
  endtask

  // stamps on both sides of the 32-bit wrap
  task automatic test_time_wrap();
    send_req(make_req(wbr_pkg::REQ_WIND, 32'hFFFF_FFF0, 16'd1234, 32'd0));
    send_req(make_req(wbr_pkg::REQ_GUST, 32'h0000_0020, 16'hFC18, 32'd0));
    send_req(make_req(wbr_pkg::REQ_WIND, 32'h0000_0100, 16'd77, 32'd0));
    send_req(make_req(wbr_pkg::REQ_QUERY, 32'h0000_0120, 16'h0000, 32'h0000_0200));
    send_req(make_req(wbr_pkg::REQ_QUERY, 32'h0000_0120, 16'h0000, 32'h0000_0031));
  endtask

  // a sample at a new time opens a new bin once the current bin is stamped
  task automatic test_step_zero();
    write_bin_step(32'd0);
    time_stride = 20;
    run_traffic(70);
  endtask

  // one bin is never closed
  task automatic test_step_max();
    write_bin_step(32'hFFFF_FFFF);
    time_stride = 1000;
    run_traffic(80);
  endtask

  task automatic test_short_bins();
    write_bin_step(32'd5);
    snd_idle_pct = 66;
    rcv_idle_pct = 14;
    time_stride  = 12;
    run_traffic(150);
  endtask

  task automatic test_long_bins();
    write_bin_step(32'd100);
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    time_stride  = 250;
    run_traffic(150);
  endtask

  // compare each summary with the oldest prediction
  always @(posedge clk) begin : check_summaries
    wbr_pkg::res_t exp_s;
    if (!rst && out_valid && out_ready) begin
      if (pending_summaries.size() == 0) begin
        note_mismatch($sformatf("unexpected summary mean %0d gust %0d count %0d valid %0b",
                                out_data.mean_wind, out_data.gust_fifth,
                                out_data.sample_count, out_data.valid_res));
      end else begin
        exp_s = pending_summaries.pop_front();
        if (out_data.mean_wind !== exp_s.mean_wind ||
            out_data.gust_fifth !== exp_s.gust_fifth ||
            out_data.sample_count !== exp_s.sample_count ||
            out_data.valid_res !== exp_s.valid_res) begin
          note_mismatch($sformatf(
            "expected mean %0d gust %0d count %0d valid %0b, got mean %0d gust %0d count %0d valid %0b",
            exp_s.mean_wind, exp_s.gust_fifth, exp_s.sample_count, exp_s.valid_res,
            out_data.mean_wind, out_data.gust_fifth, out_data.sample_count,
            out_data.valid_res));
        end else if (exp_s.valid_res) begin
          n_filled++;
        end
      end
    end
  end

  // test sequence
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_window();
    test_bin_close();
    test_time_wrap();
    test_step_zero();
    test_step_max();
    test_short_bins();
    test_long_bins();
    settle();
    if (pending_summaries.size() != 0) begin
      note_mismatch($sformatf("%0d summaries never arrived", pending_summaries.size()));
    end
    $display("covered %0d samples, %0d window queries (%0d non-empty), %0d unused codes",
             n_adds, n_queries, n_filled, n_ignored);
    $display("over %0d bin_step settings plus reset default, %0d mismatches",
             n_steps, mismatches);
    if (mismatches == 0) begin
      $display("wind_bin_ring_gust_kth_largest_test OK");
    end else begin
      $display("wind_bin_ring_gust_kth_largest_test NOT OK");
    end
    $finish;
  end

  // run time limit
  initial begin
    #5_000_000;
    $display("timeout");
    $display("wind_bin_ring_gust_kth_largest_test NOT OK");
    $finish;
  end

endmodule
